/* sv/sorted_rect_table_hit_test_defines.svh */
// assertion macros for the sorted region table hit test block
`ifndef SORTED_RECT_TABLE_HIT_TEST_DEFINES_SVH
`define SORTED_RECT_TABLE_HIT_TEST_DEFINES_SVH

// property that holds in the same cycle, checked outside reset
`define SRTH_ASSERT(lbl, expr, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (expr)) else $error(msg);

// implication into the following cycle, checked outside reset
`define SRTH_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

/* sv/srth_pkg.sv */
// shared types, widths and codes of the sorted region table hit test block
`default_nettype none
package srth_pkg;

  localparam int MAX_ENTRIES = 64;
  localparam int IDX_W       = $clog2(MAX_ENTRIES);
  localparam int CNT_W       = $clog2(MAX_ENTRIES + 1);
  localparam int PTR_W       = CNT_W + 1;

  localparam int OP_W   = 2;
  localparam int X_W    = 10;
  localparam int Y_W    = 8;
  localparam int ID_W   = 8;
  localparam int QIN_W  = 11;
  localparam int QX_W   = 13;
  localparam int QY_W   = 12;
  localparam int PAGE_W = 2;
  localparam int VW_W   = 10;
  localparam int RW_W   = 8;
  localparam int RH_W   = 8;

  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 10;

  localparam logic [CFG_IDX_W-1:0] REG_PAGE_SELECT = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_VIEW_WIDTH  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_RECT_WIDTH  = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_RECT_HEIGHT = 2'd3;

  localparam logic [PAGE_W-1:0] PAGE_ONE   = 2'd1;
  localparam logic [PAGE_W-1:0] PAGE_TWO   = 2'd2;
  localparam logic [PAGE_W-1:0] PAGE_THREE = 2'd3;

  localparam logic [PAGE_W-1:0] PAGE_RESET = 2'd1;
  localparam logic [VW_W-1:0]   VW_RESET   = 10'd280;
  localparam logic [RW_W-1:0]   RW_RESET   = 8'd25;
  localparam logic [RH_W-1:0]   RH_RESET   = 8'd25;

  typedef enum logic [OP_W-1:0] {
    OP_CLEAR  = 2'd0,
    OP_INSERT = 2'd1,
    OP_QUERY  = 2'd2
  } op_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_INS_RD,
    ST_INS_CMP,
    ST_Q_RD,
    ST_Q_CMP,
    ST_DONE
  } state_t;

  typedef struct packed {
    logic [X_W-1:0]  x;
    logic [Y_W-1:0]  y;
    logic [ID_W-1:0] id;
  } entry_t;

endpackage
`default_nettype wire

/* sv/srth_channels.sv */
// handshake channel interfaces for command words, result words and register writes
`default_nettype none
interface srth_cmd_if;
  logic                                   valid;
  logic                                   ready;
  logic        [srth_pkg::OP_W-1:0]       opcode;
  logic        [srth_pkg::X_W-1:0]        entry_x;
  logic        [srth_pkg::Y_W-1:0]        entry_y;
  logic        [srth_pkg::ID_W-1:0]       entry_id;
  logic signed [srth_pkg::QIN_W-1:0]      query_x;
  logic signed [srth_pkg::QIN_W-1:0]      query_y;

  modport source(output valid, opcode, entry_x, entry_y, entry_id, query_x, query_y,
                 input ready);
  modport sink(input valid, opcode, entry_x, entry_y, entry_id, query_x, query_y,
               output ready);
endinterface

interface srth_rsp_if;
  logic                          valid;
  logic                          ready;
  logic                          hit;
  logic [srth_pkg::ID_W-1:0]     found_id;
  logic                          table_full;

  modport source(output valid, hit, found_id, table_full, input ready);
  modport sink(input valid, hit, found_id, table_full, output ready);
endinterface

interface srth_cfg_if;
  logic                              valid;
  logic                              ready;
  logic [srth_pkg::CFG_IDX_W-1:0]    index;
  logic [srth_pkg::CFG_DATA_W-1:0]   data;

  modport source(output valid, index, data, input ready);
  modport sink(input valid, index, data, output ready);
endinterface
`default_nettype wire

/* sv/sorted_rect_table_hit_test.sv */
// Sorted region table with point hit test. Commands arrive one word at a time on cmd and each
// gives exactly one result word on rsp. The table lives in a memory with one write port and one
// read port with registered read, so every table read sets the address and then takes the data.
// Clear empties the table. Insert moves each stored entry with x greater than the new x up one
// slot, walking down from the top, and writes the new entry into the freed slot, which may be
// the lowest slot; an insert into a full table reports table_full. Query runs binary search
// probes (up to 7 for 64 entries) and ends at the first probe that holds the point in its x
// span, or on a miss once the search runs out. The next command is taken once the previous
// result is in the output register, even while that result still waits for rsp.ready. No
// clearing pass follows reset: the entry count bounds every read. Register writes on cfg are
// always taken and must only be made while the block is idle.
`default_nettype none
`include "sorted_rect_table_hit_test_defines.svh"
module sorted_rect_table_hit_test (
  input wire logic   clk,
  input wire logic   rst,
  srth_cmd_if.sink   cmd,
  srth_rsp_if.source rsp,
  srth_cfg_if.sink   cfg
);

  localparam int IDX_W = srth_pkg::IDX_W;
  localparam int CNT_W = srth_pkg::CNT_W;
  localparam int PTR_W = srth_pkg::PTR_W;
  localparam int QX_W  = srth_pkg::QX_W;
  localparam int QY_W  = srth_pkg::QY_W;

  srth_pkg::state_t state, state_next;

  logic [srth_pkg::PAGE_W-1:0] page_select;
  logic [srth_pkg::VW_W-1:0]   view_width;
  logic [srth_pkg::RW_W-1:0]   rect_width;
  logic [srth_pkg::RH_W-1:0]   rect_height;

  logic [CNT_W-1:0]        entry_count, entry_count_next;
  logic [IDX_W-1:0]        pos, pos_next;
  logic [IDX_W-1:0]        mid, mid_next;
  logic signed [PTR_W-1:0] lo, lo_next;
  logic signed [PTR_W-1:0] hi, hi_next;
  logic signed [PTR_W-1:0] mid_c;
  srth_pkg::entry_t        new_ent, new_ent_next;
  logic signed [QX_W-1:0]  qx, qx_next;
  logic signed [QY_W-1:0]  qy, qy_next;
  logic                    res_hit, res_hit_next;
  logic [srth_pkg::ID_W-1:0] res_id, res_id_next;
  logic                    res_full, res_full_next;

  logic                    out_valid;
  logic                    out_hit;
  logic [srth_pkg::ID_W-1:0] out_id;
  logic                    out_full;
  logic                    out_load;

  logic                    ram_we;
  logic [IDX_W-1:0]        ram_waddr;
  srth_pkg::entry_t        ram_wdata;
  logic [IDX_W-1:0]        ram_raddr;
  srth_pkg::entry_t        rd_ent;

  logic                    is_full;
  logic                    lo_gt_hi;
  logic                    x_in, y_in, x_left;
  logic                    shift_up;
  logic [QX_W-1:0]         page_offset;
  logic signed [QX_W-1:0]  qx_in;
  logic signed [QX_W-1:0]  x_lo_s, x_hi_s;
  logic signed [QY_W-1:0]  y_lo_s, y_hi_s;

  srth_ram #(
    .WIDTH($bits(srth_pkg::entry_t)),
    .DEPTH(srth_pkg::MAX_ENTRIES)
  ) u_table (
    .clk  (clk),
    .we   (ram_we),
    .waddr(ram_waddr),
    .wdata(ram_wdata),
    .raddr(ram_raddr),
    .rdata(rd_ent)
  );

  // configuration registers
  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      page_select <= srth_pkg::PAGE_RESET;
      view_width  <= srth_pkg::VW_RESET;
      rect_width  <= srth_pkg::RW_RESET;
      rect_height <= srth_pkg::RH_RESET;
    end else if (cfg.valid) begin
      case (cfg.index)
        srth_pkg::REG_PAGE_SELECT: page_select <= cfg.data[srth_pkg::PAGE_W-1:0];
        srth_pkg::REG_VIEW_WIDTH:  view_width  <= cfg.data[srth_pkg::VW_W-1:0];
        srth_pkg::REG_RECT_WIDTH:  rect_width  <= cfg.data[srth_pkg::RW_W-1:0];
        srth_pkg::REG_RECT_HEIGHT: rect_height <= cfg.data[srth_pkg::RH_W-1:0];
        default: begin
        end
      endcase
    end
  end

  // page offset and conditions
  always_comb begin
    case (page_select)
      srth_pkg::PAGE_TWO:   page_offset = QX_W'(view_width);
      srth_pkg::PAGE_THREE: page_offset = QX_W'({view_width, 1'b0});
      default:              page_offset = '0;
    endcase
  end

  assign qx_in = QX_W'(cmd.query_x) + $signed(page_offset);

  assign x_lo_s = $signed(QX_W'(rd_ent.x));
  assign x_hi_s = $signed(QX_W'(rd_ent.x) + QX_W'(rect_width));
  assign y_lo_s = $signed(QY_W'(rd_ent.y));
  assign y_hi_s = $signed(QY_W'(rd_ent.y) + QY_W'(rect_height));

  assign x_in     = (qx > x_lo_s) && (qx < x_hi_s);
  assign y_in     = (qy > y_lo_s) && (qy < y_hi_s);
  assign x_left   = (qx < x_lo_s);
  assign shift_up = (rd_ent.x > new_ent.x);
  assign is_full  = (entry_count == CNT_W'(srth_pkg::MAX_ENTRIES));
  assign lo_gt_hi = (lo > hi);
  assign mid_c    = lo + ((hi - lo) >>> 1);

  assign cmd.ready = (state == srth_pkg::ST_IDLE);

  // next state
  always_comb begin
    state_next = state;
    case (state)
      srth_pkg::ST_IDLE: begin
        if (cmd.valid) begin
          case (srth_pkg::op_t'(cmd.opcode))
            srth_pkg::OP_INSERT: state_next = is_full ? srth_pkg::ST_DONE : srth_pkg::ST_INS_RD;
            srth_pkg::OP_QUERY:  state_next = srth_pkg::ST_Q_RD;
            default:             state_next = srth_pkg::ST_DONE;
          endcase
        end
      end
      srth_pkg::ST_INS_RD: begin
        state_next = (pos == '0) ? srth_pkg::ST_DONE : srth_pkg::ST_INS_CMP;
      end
      srth_pkg::ST_INS_CMP: begin
        state_next = shift_up ? srth_pkg::ST_INS_RD : srth_pkg::ST_DONE;
      end
      srth_pkg::ST_Q_RD: begin
        state_next = lo_gt_hi ? srth_pkg::ST_DONE : srth_pkg::ST_Q_CMP;
      end
      srth_pkg::ST_Q_CMP: begin
        state_next = x_in ? srth_pkg::ST_DONE : srth_pkg::ST_Q_RD;
      end
      srth_pkg::ST_DONE: begin
        if (!out_valid || rsp.ready) begin
          state_next = srth_pkg::ST_IDLE;
        end
      end
      default: state_next = srth_pkg::ST_IDLE;
    endcase
  end

  // datapath control
  always_comb begin
    ram_we           = 1'b0;
    ram_waddr        = pos;
    ram_wdata        = new_ent;
    ram_raddr        = pos - IDX_W'(1);
    entry_count_next = entry_count;
    pos_next         = pos;
    mid_next         = mid;
    lo_next          = lo;
    hi_next          = hi;
    new_ent_next     = new_ent;
    qx_next          = qx;
    qy_next          = qy;
    res_hit_next     = res_hit;
    res_id_next      = res_id;
    res_full_next    = res_full;
    out_load         = 1'b0;
    case (state)
      srth_pkg::ST_IDLE: begin
        if (cmd.valid) begin
          res_hit_next  = 1'b0;
          res_id_next   = '0;
          res_full_next = 1'b0;
          case (srth_pkg::op_t'(cmd.opcode))
            srth_pkg::OP_CLEAR: begin
              entry_count_next = '0;
            end
            srth_pkg::OP_INSERT: begin
              if (is_full) begin
                res_full_next = 1'b1;
              end else begin
                pos_next     = entry_count[IDX_W-1:0];
                new_ent_next = '{x: cmd.entry_x, y: cmd.entry_y, id: cmd.entry_id};
              end
            end
            srth_pkg::OP_QUERY: begin
              lo_next = '0;
              hi_next = $signed(PTR_W'(entry_count)) - PTR_W'(1);
              qx_next = qx_in;
              qy_next = QY_W'(cmd.query_y);
            end
            default: begin
            end
          endcase
        end
      end
      srth_pkg::ST_INS_RD: begin
        if (pos == '0) begin
          ram_we           = 1'b1;
          entry_count_next = entry_count + CNT_W'(1);
        end
      end
      srth_pkg::ST_INS_CMP: begin
        ram_we = 1'b1;
        if (shift_up) begin
          ram_wdata = rd_ent;
          pos_next  = pos - IDX_W'(1);
        end else begin
          entry_count_next = entry_count + CNT_W'(1);
        end
      end
      srth_pkg::ST_Q_RD: begin
        ram_raddr = mid_c[IDX_W-1:0];
        mid_next  = mid_c[IDX_W-1:0];
      end
      srth_pkg::ST_Q_CMP: begin
        ram_raddr = mid;
        if (x_in) begin
          res_hit_next = y_in;
          res_id_next  = y_in ? rd_ent.id : '0;
        end else if (x_left) begin
          hi_next = $signed(PTR_W'(mid)) - PTR_W'(1);
        end else begin
          lo_next = $signed(PTR_W'(mid)) + PTR_W'(1);
        end
      end
      srth_pkg::ST_DONE: begin
        out_load = !out_valid || rsp.ready;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= srth_pkg::ST_IDLE;
      entry_count <= '0;
    end else begin
      state       <= state_next;
      entry_count <= entry_count_next;
    end
  end

  always_ff @(posedge clk) begin
    pos      <= pos_next;
    mid      <= mid_next;
    lo       <= lo_next;
    hi       <= hi_next;
    new_ent  <= new_ent_next;
    qx       <= qx_next;
    qy       <= qy_next;
    res_hit  <= res_hit_next;
    res_id   <= res_id_next;
    res_full <= res_full_next;
  end

  // output register, holds a result word until taken
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_load) begin
      out_valid <= 1'b1;
    end else if (rsp.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_hit  <= res_hit;
      out_id   <= res_id;
      out_full <= res_full;
    end
  end

  assign rsp.valid      = out_valid;
  assign rsp.hit        = out_hit;
  assign rsp.found_id   = out_id;
  assign rsp.table_full = out_full;

  `SRTH_ASSERT_NEXT(a_clear_empties, cmd.valid && cmd.ready && cmd.opcode == srth_pkg::OP_CLEAR, entry_count == '0, "clear did not empty the table")
  `SRTH_ASSERT(a_count_bound, entry_count <= CNT_W'(srth_pkg::MAX_ENTRIES), "entry count above table depth")
  `SRTH_ASSERT(a_write_in_insert, !ram_we || state == srth_pkg::ST_INS_RD || state == srth_pkg::ST_INS_CMP, "table written outside insert")
  `SRTH_ASSERT(a_probe_in_range, state != srth_pkg::ST_Q_CMP || CNT_W'(mid) < entry_count, "query probe beyond stored entries")

endmodule
`default_nettype wire

/* sv/srth_ram.sv */
// generic single-write, single-read ram with registered read data
`default_nettype none
module srth_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule
`default_nettype wire
